### hw/rtl/ctpq_pkg.sv
`timescale 1ns / 1ps
package ctpq_pkg;
  localparam int PoolDepth = 16;
  localparam int Levels = 4;
  localparam int LevelCap = PoolDepth / Levels;
  localparam int SlotW = $clog2(PoolDepth);
  localparam int LvlW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int PosW = (LevelCap > 1) ? $clog2(LevelCap) : 1;
  localparam int CntW = $clog2(LevelCap + 1);
  localparam int UsedW = 5;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_TAKE = 2'd1;
  localparam logic [1:0] REQ_ABORT = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_BAD_PRIO = 3'd2;
  localparam logic [2:0] ST_NO_TAG = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_NOT_STARTED = 3'd5;

  // one request as it passes from the in_ channel through front and back
  typedef struct packed {
    logic [1:0] req_type;
    logic [28:0] can_id;
    logic extended;
    logic remote;
    logic [3:0] data_len;
    logic [63:0] payload;
    logic [2:0] priority_req;
    logic [31:0] tx_tag;
  } ctpq_req_t;

  // one result
  typedef struct packed {
    logic [2:0] status;
    logic [31:0] tx_tag;
    logic [28:0] can_id;
    logic extended;
    logic remote;
    logic [3:0] data_len;
    logic [63:0] payload;
    logic [4:0] slots_used;
  } ctpq_res_t;
endpackage

### hw/rtl/ctpq_front.sv
`timescale 1ns / 1ps
module ctpq_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  ctpq_pkg::ctpq_req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output ctpq_pkg::ctpq_req_t q_req
);
  import ctpq_pkg::*;

  // two-entry request queue
  ctpq_req_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) mem_r[wp_r] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_tvalid && in_tready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_tvalid && in_tready) - 2'(q_valid && q_ready);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !(q_valid && q_ready))
    else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_tready)
    else $error("accept while full");
endmodule

### hw/rtl/ctpq_back.sv
`timescale 1ns / 1ps
module ctpq_back (
  input  logic clk,
  input  logic rst_n,
  input  logic enabled,
  input  logic q_valid,
  output logic q_ready,
  input  ctpq_pkg::ctpq_req_t q_req,
  output logic res_valid,
  input  logic res_ready,
  output ctpq_pkg::ctpq_res_t res
);
  import ctpq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TAKE_RD, S_SCAN, S_SHIFT, S_DONE} state_t;

  // slot stores and rings, no reset; busy map, pointers and counts are reset
  logic [63:0] pay_r [PoolDepth];
  logic [34:0] hdr_r [PoolDepth];
  logic [31:0] tag_r [PoolDepth];
  logic [SlotW-1:0] ring_r [Levels][LevelCap];
  logic [PoolDepth-1:0] busy_r;
  logic [PosW-1:0] head_r [Levels];
  logic [PosW-1:0] tail_r [Levels];
  logic [CntW-1:0] lcnt_r [Levels];
  logic [UsedW-1:0] used_r;

  state_t state_r;
  ctpq_req_t cur_r;
  ctpq_res_t res_r;
  logic res_valid_r;
  logic [LvlW-1:0] lvl_r;
  logic [CntW-1:0] idx_r;
  logic [SlotW-1:0] slot_r;

  assign q_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res = res_r;

  // lowest free slot
  logic [SlotW-1:0] free_s;
  logic free_any;
  always_comb begin
    free_s = '0;
    free_any = 1'b0;
    for (int i = PoolDepth - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_s = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end

  // lowest nonempty level
  logic [LvlW-1:0] top_l;
  logic top_any;
  always_comb begin
    top_l = '0;
    top_any = 1'b0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (lcnt_r[i] != '0) begin
        top_l = LvlW'(i);
        top_any = 1'b1;
      end
    end
  end

  function automatic logic [PosW-1:0] pos_add(input logic [PosW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW+PosW:0] s;
    s = (CntW + PosW + 1)'(a) + (CntW + PosW + 1)'(b);
    if (s >= (CntW + PosW + 1)'(LevelCap)) s = s - (CntW + PosW + 1)'(LevelCap);
    return PosW'(s);
  endfunction

  logic [LvlW-1:0] prio;
  logic [PosW-1:0] scan_pos;
  logic [SlotW-1:0] scan_s;
  assign prio = LvlW'(q_req.priority_req);
  assign scan_pos = pos_add(head_r[lvl_r], idx_r);
  assign scan_s = ring_r[lvl_r][scan_pos];

  // classify the request waiting at the back
  ctpq_res_t idle_res;
  state_t idle_state;
  logic sub_ok;
  always_comb begin
    idle_res = '0;
    idle_res.slots_used = used_r;
    idle_state = S_DONE;
    sub_ok = 1'b0;
    case (q_req.req_type)
      REQ_SUBMIT: begin
        if (32'(q_req.priority_req) >= Levels) idle_res.status = ST_BAD_PRIO;
        else if (!enabled) idle_res.status = ST_NOT_STARTED;
        else if (!free_any || 32'(lcnt_r[prio]) >= LevelCap)
          idle_res.status = ST_FULL;
        else begin
          sub_ok = 1'b1;
          idle_res.status = ST_OK;
          idle_res.slots_used = used_r + 1'b1;
        end
      end
      REQ_TAKE: begin
        if (!top_any) idle_res.status = ST_EMPTY;
        else idle_state = S_TAKE_RD;
      end
      REQ_ABORT: idle_state = S_SCAN;
      default: idle_res.status = ST_BAD_PRIO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_valid_r <= 1'b0;
      busy_r <= '0;
      used_r <= '0;
      for (int i = 0; i < Levels; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        lcnt_r[i] <= '0;
      end
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur_r <= q_req;
            res_r <= idle_res;
            state_r <= idle_state;
            if (sub_ok) begin
              pay_r[free_s] <= q_req.payload;
              hdr_r[free_s] <= {q_req.data_len, q_req.remote, q_req.extended,
                                q_req.can_id};
              tag_r[free_s] <= q_req.tx_tag;
              busy_r[free_s] <= 1'b1;
              used_r <= used_r + 1'b1;
              ring_r[prio][tail_r[prio]] <= free_s;
              tail_r[prio] <= pos_add(tail_r[prio], CntW'(1));
              lcnt_r[prio] <= lcnt_r[prio] + 1'b1;
            end
            if (q_req.req_type == REQ_TAKE && top_any) begin
              slot_r <= ring_r[top_l][head_r[top_l]];
              head_r[top_l] <= pos_add(head_r[top_l], CntW'(1));
              lcnt_r[top_l] <= lcnt_r[top_l] - 1'b1;
            end
            if (q_req.req_type == REQ_ABORT) begin
              lvl_r <= '0;
              idx_r <= '0;
            end
          end
        end
        // read the slot and free it
        S_TAKE_RD: begin
          res_r.status <= ST_OK;
          res_r.tx_tag <= tag_r[slot_r];
          {res_r.data_len, res_r.remote, res_r.extended, res_r.can_id} <= hdr_r[slot_r];
          res_r.payload <= pay_r[slot_r];
          busy_r[slot_r] <= 1'b0;
          used_r <= used_r - 1'b1;
          res_r.slots_used <= used_r - 1'b1;
          state_r <= S_DONE;
        end
        // one ring entry per cycle
        S_SCAN: begin
          if (idx_r >= lcnt_r[lvl_r]) begin
            idx_r <= '0;
            if (32'(lvl_r) == Levels - 1) begin
              res_r.status <= ST_NO_TAG;
              state_r <= S_DONE;
            end else lvl_r <= lvl_r + 1'b1;
          end else if (tag_r[scan_s] == cur_r.tx_tag) begin
            busy_r[scan_s] <= 1'b0;
            used_r <= used_r - 1'b1;
            res_r.slots_used <= used_r - 1'b1;
            res_r.status <= ST_OK;
            state_r <= S_SHIFT;
          end else idx_r <= idx_r + 1'b1;
        end
        // close the gap one entry per cycle
        S_SHIFT: begin
          if (idx_r + 1'b1 < lcnt_r[lvl_r]) begin
            ring_r[lvl_r][scan_pos] <= ring_r[lvl_r][pos_add(scan_pos, CntW'(1))];
            idx_r <= idx_r + 1'b1;
          end else begin
            tail_r[lvl_r] <= (tail_r[lvl_r] == '0) ? PosW'(LevelCap - 1)
                                                   : tail_r[lvl_r] - 1'b1;
            lcnt_r[lvl_r] <= lcnt_r[lvl_r] - 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= PoolDepth)
    else $error("used count beyond pool");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(busy_r) == 32'(used_r))
    else $error("busy map and used count differ");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> res_valid_r)
    else $error("result not presented");
endmodule

### hw/rtl/can_tx_priority_queue.sv
`timescale 1ns / 1ps
// CAN transmit queue with strict priority over a shared pool of 16 slots
// in four levels (level 0 highest). Requests arrive on the in_ channel:
// submit, take next (a mailbox is free) or abort by tag. Each request
// gives exactly one result on the out_ channel with a status, the frame
// taken (take only, else zero) and the slot count after the request.
// The front buffers up to two requests; the back handles one at a time.
// A take reads and frees its slot before the result; an abort scans the
// ring entries level by level and on a hit moves the later entries up.
// The back is busy until its result register is taken, so a stalled
// receiver fills the queue and then holds in_tready low. cfg_ sets
// transmit_enabled; write only when idle.
// Reset empties all levels and clears transmit_enabled.
module can_tx_priority_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // req_type, can_id, extended, remote, data_len, payload, priority_req, tx_tag
  input  logic [135:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status, out_tx_tag, out_can_id, out_extended, out_remote, out_len,
  // out_payload, slots_used
  output logic [143:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);
  import ctpq_pkg::*;

  logic en_r;
  ctpq_req_t in_req, q_req;
  ctpq_res_t res;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) en_r <= 1'b0;
    else if (cfg_valid) en_r <= cfg_data;
  end

  // unpack request
  assign in_req.req_type = in_tdata[1:0];
  assign in_req.can_id = in_tdata[30:2];
  assign in_req.extended = in_tdata[31];
  assign in_req.remote = in_tdata[32];
  assign in_req.data_len = in_tdata[36:33];
  assign in_req.payload = in_tdata[100:37];
  assign in_req.priority_req = in_tdata[103:101];
  assign in_req.tx_tag = in_tdata[135:104];

  // pack result
  assign out_tdata = {5'b0, res.slots_used, res.payload, res.data_len, res.remote,
                      res.extended, res.can_id, res.tx_tag, res.status};

  ctpq_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_req,
    .q_valid, .q_ready, .q_req
  );

  ctpq_back u_back (
    .clk, .rst_n, .enabled(en_r), .q_valid, .q_ready, .q_req,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );
endmodule
